>>> rtl/cqe_pkg.sv
// Package for the circular queue engine.
// Holds field widths, parameter defaults, operation and status codes,
// and the result control struct passed from the controller to the top level.
package cqe_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int DATA_BITS         = 32;
    localparam int CAP_BITS          = 7;
    localparam int OP_BITS           = 2;
    localparam int STATUS_BITS       = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_TRAV = 2'd2
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    valid;
        logic    from_mem;
        status_t status;
        logic    last;
        logic    empty;
        logic    full;
    } res_ctl_t;

endpackage

>>> rtl/cqe_mem.sv
// Slot memory of the circular queue engine.
// One write port and one registered read port; uses no package items.
module cqe_mem #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    parameter int AW        = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem_array [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> rtl/cqe_ctrl.sv
// Controller of the circular queue engine: capacity, head and tail indices,
// empty flag, traversal sequencer and memory addressing.
// Depends on cqe_pkg for codes and the result control struct.
module cqe_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cqe_pkg::OP_BITS-1:0]   op,
    output logic                          busy,
    input  logic                          cap_we,
    input  logic [cqe_pkg::CAP_BITS-1:0]  cap_data,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [AW-1:0]                 mem_raddr,
    output cqe_pkg::res_ctl_t             res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TRAV = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              cap_reg, cap_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              tail_reg, tail_next;
    logic                       empty_reg, empty_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_mem_reg, pend_mem_next;
    cqe_pkg::status_t           pend_status_reg, pend_status_next;
    logic                       pend_last_reg, pend_last_next;
    logic                       accept;
    logic                       full;
    logic                       fin;
    logic [AW-1:0]              tail_inc;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cap);
        logic [CW:0] sum;
        sum = (CW+1)'(idx) + (CW+1)'(1);
        if (sum >= (CW+1)'(cap))
            return '0;
        return AW'(sum);
    endfunction

    function automatic logic [CW-1:0] eff_cap(input logic [cqe_pkg::CAP_BITS-1:0] v);
        if (v == '0)
            return CW'(1);
        if (v > cqe_pkg::CAP_BITS'(DEPTH))
            return CW'(DEPTH);
        return CW'(v);
    endfunction

    assign busy     = (state_reg != ST_IDLE) || pend_valid_reg;
    assign accept   = start && !busy;
    assign tail_inc = next_idx(tail_reg, cap_reg);
    assign full     = !empty_reg && (tail_inc == head_reg);
    assign fin      = (ptr_reg == tail_reg) || (cnt_reg == CW'(DEPTH - 1));

    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        empty_next       = empty_reg;
        ptr_next         = ptr_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = 1'b0;
        pend_mem_next    = 1'b0;
        pend_status_next = cqe_pkg::STATUS_OK;
        pend_last_next   = 1'b1;
        mem_we           = 1'b0;
        mem_waddr        = tail_inc;
        mem_raddr        = head_reg;

        if (cap_we && empty_reg)
        begin
            cap_next  = eff_cap(cap_data);
            head_next = '0;
            tail_next = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        cqe_pkg::OP_ENQ:
                        begin
                            pend_valid_next = 1'b1;
                            if (full)
                            begin
                                pend_status_next = cqe_pkg::STATUS_FULL;
                            end
                            else if (empty_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = tail_inc;
                            end
                        end
                        cqe_pkg::OP_DEQ:
                        begin
                            pend_valid_next = 1'b1;
                            if (empty_reg)
                            begin
                                pend_status_next = cqe_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                pend_mem_next = 1'b1;
                                if (head_reg == tail_reg)
                                begin
                                    empty_next = 1'b1;
                                    head_next  = '0;
                                    tail_next  = '0;
                                end
                                else
                                begin
                                    head_next = next_idx(head_reg, cap_reg);
                                end
                            end
                        end
                        cqe_pkg::OP_TRAV:
                        begin
                            if (empty_reg)
                            begin
                                pend_valid_next  = 1'b1;
                                pend_status_next = cqe_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_TRAV;
                                ptr_next   = head_reg;
                                cnt_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRAV:
            begin
                mem_raddr       = ptr_reg;
                pend_valid_next = 1'b1;
                pend_mem_next   = 1'b1;
                pend_last_next  = fin;
                ptr_next        = next_idx(ptr_reg, cap_reg);
                cnt_next        = cnt_reg + CW'(1);
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cap_reg         <= CW'(DEPTH);
            head_reg        <= '0;
            tail_reg        <= '0;
            empty_reg       <= 1'b1;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_mem_reg    <= 1'b0;
            pend_status_reg <= cqe_pkg::STATUS_OK;
            pend_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cap_reg         <= cap_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            empty_reg       <= empty_next;
            ptr_reg         <= ptr_next;
            cnt_reg         <= cnt_next;
            pend_valid_reg  <= pend_valid_next;
            pend_mem_reg    <= pend_mem_next;
            pend_status_reg <= pend_status_next;
            pend_last_reg   <= pend_last_next;
        end
    end

    always_comb
    begin
        res.valid    = pend_valid_reg;
        res.from_mem = pend_mem_reg;
        res.status   = pend_status_reg;
        res.last     = pend_last_reg;
        res.empty    = empty_reg;
        res.full     = full;
    end

endmodule

>>> rtl/circular_queue_engine.sv
// Circular queue engine: a FIFO of signed words with a programmable capacity.
// An accepted request raises busy while its result is pending in the controller;
// the result passes through the controller's pending register and the output
// register before it is strobed, and a new request can be taken in that strobe
// cycle. A traverse keeps busy high while it walks the stored words and strobes
// one word per cycle, paced by the single registered read port of the slot
// memory. Results cannot be held off: each is valid for exactly the cycle in
// which strobe is high. Capacity writes take effect only while the queue is empty.
// Depends on cqe_pkg, cqe_mem and cqe_ctrl.
module circular_queue_engine #(
    parameter int DEPTH     = cqe_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = cqe_pkg::WORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [cqe_pkg::OP_BITS-1:0]          op,
    input  logic signed [cqe_pkg::DATA_BITS-1:0] value,
    input  logic                                 cap_we,
    input  logic [cqe_pkg::CAP_BITS-1:0]         cap_data,
    output logic                                 strobe,
    output logic signed [cqe_pkg::DATA_BITS-1:0] data,
    output logic [cqe_pkg::STATUS_BITS-1:0]      status,
    output logic                                 last,
    output logic                                 is_empty,
    output logic                                 is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [WORD_BITS-1:0]          mem_rdata;
    cqe_pkg::res_ctl_t             res;

    logic                          strobe_reg;
    logic [cqe_pkg::DATA_BITS-1:0] data_reg;
    cqe_pkg::status_t              status_reg;
    logic                          last_reg;
    logic                          empty_reg;
    logic                          full_reg;

    cqe_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .busy      (busy),
        .cap_we    (cap_we),
        .cap_data  (cap_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_raddr (mem_raddr),
        .res       (res)
    );

    cqe_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (WORD_BITS'(value)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= res.from_mem ? cqe_pkg::DATA_BITS'(mem_rdata) : '0;
        status_reg <= res.status;
        last_reg   <= res.last;
        empty_reg  <= res.empty;
        full_reg   <= res.full;
    end

    assign strobe   = strobe_reg;
    assign data     = data_reg;
    assign status   = status_reg;
    assign last     = last_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

`ifndef SYNTHESIS
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobed without a request in progress");

    a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && is_empty |-> !is_full)
        else $error("queue reported both empty and full");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == cqe_pkg::OP_ENQ || op == cqe_pkg::OP_DEQ
            || op == cqe_pkg::OP_TRAV) |=> busy)
        else $error("accepted request did not raise busy");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == cqe_pkg::STATUS_EMPTY |-> last && data == '0)
        else $error("empty result with data or without last");
`endif

endmodule

>>> tb/circular_queue_engine_tb.sv
// Self-checking testbench for the circular queue engine: directed and random requests.
// A scoreboard class predicts every result and checks each strobed result against it.
// Depends on cqe_pkg and circular_queue_engine.
`timescale 1ns / 100ps

module circular_queue_engine_tb;

    import cqe_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int QUEUE_SLOTS = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQUESTS = 370;

    typedef struct {
        logic [DATA_BITS-1:0] data;
        status_t status;
        logic last;
        logic empty;
        logic full;
    } queue_result_t;

    class cq_scoreboard;
        logic [DATA_BITS-1:0] word_store [QUEUE_SLOTS];
        int unsigned head_ptr;
        int unsigned tail_ptr;
        bit drained;
        logic [CAP_BITS-1:0] cap_reg;
        queue_result_t pending_results[$];
        int errors;

        function new();
            head_ptr = 0;
            tail_ptr = 0;
            drained = 1'b1;
            cap_reg = 7'd64;
            errors = 0;
        endfunction

        function int unsigned usable();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > QUEUE_SLOTS)
                return QUEUE_SLOTS;
            return cap_reg;
        endfunction

        function int unsigned step_index(int unsigned i);
            return (i + 1 >= usable()) ? 0 : i + 1;
        endfunction

        function bit at_full();
            return !drained && step_index(tail_ptr) == head_ptr;
        endfunction

        function int unsigned occupancy();
            if (drained)
                return 0;
            return ((tail_ptr + usable() - head_ptr) % usable()) + 1;
        endfunction

        function void push_result(logic [DATA_BITS-1:0] d, status_t s, logic l);
            queue_result_t r;
            r.data = d;
            r.status = s;
            r.last = l;
            r.empty = drained;
            r.full = at_full();
            pending_results.push_back(r);
        endfunction

        function void write_capacity(logic [CAP_BITS-1:0] v);
            if (!drained)
                return;
            cap_reg = v;
            head_ptr = 0;
            tail_ptr = 0;
        endfunction

        function void note_request(logic [OP_BITS-1:0] o, logic [DATA_BITS-1:0] v);
            logic [DATA_BITS-1:0] word;
            int unsigned i;
            int n;
            bit fin;
            case (o)
                OP_ENQ:
                begin
                    if (at_full())
                    begin
                        push_result('0, STATUS_FULL, 1'b1);
                    end
                    else
                    begin
                        if (drained)
                        begin
                            head_ptr = 0;
                            tail_ptr = 0;
                            drained = 1'b0;
                        end
                        else
                        begin
                            tail_ptr = step_index(tail_ptr);
                        end
                        word_store[tail_ptr] = v;
                        push_result('0, STATUS_OK, 1'b1);
                    end
                end
                OP_DEQ:
                begin
                    if (drained)
                    begin
                        push_result('0, STATUS_EMPTY, 1'b1);
                    end
                    else
                    begin
                        word = word_store[head_ptr];
                        if (head_ptr == tail_ptr)
                        begin
                            drained = 1'b1;
                            head_ptr = 0;
                            tail_ptr = 0;
                        end
                        else
                        begin
                            head_ptr = step_index(head_ptr);
                        end
                        push_result(word, STATUS_OK, 1'b1);
                    end
                end
                OP_TRAV:
                begin
                    if (drained)
                    begin
                        push_result('0, STATUS_EMPTY, 1'b1);
                    end
                    else
                    begin
                        i = head_ptr;
                        n = 0;
                        fin = 1'b0;
                        while (!fin)
                        begin
                            fin = (i == tail_ptr) || (n + 1 >= QUEUE_SLOTS);
                            push_result(word_store[i], STATUS_OK, fin);
                            n++;
                            i = step_index(i);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [DATA_BITS-1:0] d, logic [STATUS_BITS-1:0] s,
                                   logic l, logic e, logic f);
            queue_result_t r;
            if (pending_results.size() == 0)
            begin
                $error("result strobed with no request outstanding");
                errors++;
                return;
            end
            r = pending_results.pop_front();
            if (d !== r.data)
            begin
                $error("data: expected %0d, actual %0d", $signed(r.data), $signed(d));
                errors++;
            end
            if (s !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, s);
                errors++;
            end
            if (l !== r.last)
            begin
                $error("last: expected %0b, actual %0b", r.last, l);
                errors++;
            end
            if (e !== r.empty)
            begin
                $error("is_empty: expected %0b, actual %0b", r.empty, e);
                errors++;
            end
            if (f !== r.full)
            begin
                $error("is_full: expected %0b, actual %0b", r.full, f);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [OP_BITS-1:0] op = OP_ENQ;
    logic signed [DATA_BITS-1:0] value = '0;
    logic cap_we = 1'b0;
    logic [CAP_BITS-1:0] cap_data = '0;
    logic strobe;
    logic signed [DATA_BITS-1:0] data;
    logic [STATUS_BITS-1:0] status;
    logic last;
    logic is_empty;
    logic is_full;

    cq_scoreboard sb = new();
    bit gaps_on = 1'b1;
    int requests_sent = 0;
    int cycle_count = 0;

    circular_queue_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .value    (value),
        .cap_we   (cap_we),
        .cap_data (cap_data),
        .strobe   (strobe),
        .data     (data),
        .status   (status),
        .last     (last),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                sb.check_result(data, status, last, is_empty, is_full);
            if (start && !busy)
                sb.note_request(op, value);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[circular_queue_engine] ERROR");
            $finish;
        end
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input logic [OP_BITS-1:0] o, input logic [DATA_BITS-1:0] v);
        if (gaps_on && $urandom_range(0, 99) < 25)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (o != OP_UNUSED)
            requests_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity_reg(input logic [CAP_BITS-1:0] v);
        cap_we <= 1'b1;
        cap_data <= v;
        @(posedge clk);
        sb.write_capacity(v);
        cap_we <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int target;
        int pick;
        int enq_pct;
        logic [CAP_BITS-1:0] cap;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty-queue cases, extreme words, a traverse, and draining to empty.
        issue(OP_DEQ, rand_word());
        issue(OP_TRAV, rand_word());
        issue(OP_UNUSED, rand_word());
        issue(OP_ENQ, 32'h7FFF_FFFF);
        issue(OP_ENQ, 32'h8000_0000);
        issue(OP_ENQ, 32'h0000_0000);
        issue(OP_ENQ, 32'hFFFF_FFFF);
        issue(OP_TRAV, rand_word());
        repeat (4) issue(OP_DEQ, rand_word());
        wait_idle();

        // A capacity of zero acts as one slot: fill, reject, traverse, dequeue, refill.
        write_capacity_reg(7'd0);
        issue(OP_ENQ, rand_word());
        issue(OP_ENQ, rand_word());
        issue(OP_TRAV, rand_word());
        issue(OP_DEQ, rand_word());
        issue(OP_ENQ, rand_word());
        wait_idle();

        // This write must be ignored because the queue is not empty.
        write_capacity_reg(7'd5);
        issue(OP_ENQ, rand_word());
        issue(OP_DEQ, rand_word());
        wait_idle();
        write_capacity_reg(7'd127);

        target = requests_sent + RANDOM_REQUESTS;
        phase = 0;
        while (requests_sent < target)
        begin
            while (sb.occupancy() != 0)
                issue(OP_DEQ, rand_word());
            wait_idle();
            case (phase % 6)
                0: cap = 7'd64;
                1: cap = 7'($urandom_range(2, 8));
                2: cap = 7'($urandom_range(0, 127));
                3: cap = 7'd127;
                4: cap = 7'($urandom_range(9, 40));
                default: cap = 7'd1;
            endcase
            write_capacity_reg(cap);
            gaps_on = (phase != 2);
            if (phase % 3 == 0)
            begin
                repeat (sb.usable() + 1) issue(OP_ENQ, rand_word());
                enq_pct = 40;
            end
            else
            begin
                enq_pct = 62;
            end
            repeat (32)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    issue(OP_UNUSED, rand_word());
                else if (pick < enq_pct)
                    issue(OP_ENQ, rand_word());
                else if (pick < 88)
                    issue(OP_DEQ, rand_word());
                else
                    issue(OP_TRAV, rand_word());
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[circular_queue_engine] OK");
        else
            $display("[circular_queue_engine] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/cqe_pkg.sv
rtl/cqe_mem.sv
rtl/cqe_ctrl.sv
rtl/circular_queue_engine.sv
tb/circular_queue_engine_tb.sv
